/* src/tcgd_pkg.sv */
package tcgd_pkg;

   // result codes
   typedef enum logic [2:0] {
      EV_DOWN    = 3'd0,
      EV_TOUCH   = 3'd1,
      EV_UP      = 3'd2,
      EV_CLICK   = 3'd3,
      EV_NOTOUCH = 3'd4
   } event_kind_type;

   // register port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CLICK_MS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOVE_THRESHOLD_PX = 2'd1;

   localparam logic [15:0] MAX_CLICK_MS_RESET      = 16'd300;
   localparam logic [9:0]  MOVE_THRESHOLD_PX_RESET = 10'd10;

   // squares stage contents handed from front end to event stage
   typedef struct packed {
      logic               release_item;
      logic               first_press;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [33:0]        dx_sq;
      logic [33:0]        dy_sq;
      logic [19:0]        thr_sq;
      logic [31:0]        elapsed;
   } stage_type;

endpackage

/* src/touch_click_gesture_detector.sv */
// touch click gesture detector
// req_ channel: one touch panel sample per item (action, pos_x, pos_y, time_ms),
// accepted at a clock edge with req_valid high and req_stall low
// rsp_ channel: one gesture event per item (event_kind, event_x, event_y,
// last_of_run); a press gives down+touch on first contact or touch alone,
// a release gives up, click when the tap was short and still, then no touch;
// a release while untouched gives nothing
// csr_ channel: register writes (0 max_click_ms, 1 move_threshold_px),
// always ready, write only while no item is in flight
// pipeline: input register, squares register, event burst register;
// the first event of an item shows on rsp_ once it has passed the squares register
// throughput: one item per cycle into the input register while req_stall is low; the
// burst register emits one event per cycle while rsp_stall is low, so an item holds the
// event stage until all of its events (one to three) are out and that sets the sustained rate
// rsp_stall freezes the head event; the stages behind it fill and then
// req_stall rises, nothing is dropped
// reset: synchronous, clears the pipeline and touch state, registers go to
// max_click_ms 300 and move_threshold_px 10
module touch_click_gesture_detector (
   input  logic                                clock,
   input  logic                                reset,
   // sample items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [15:0]                  req_pos_x,
   input  logic signed [15:0]                  req_pos_y,
   input  logic [31:0]                         req_time_ms,
   // event items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_event_kind,
   output logic signed [15:0]                  rsp_event_x,
   output logic signed [15:0]                  rsp_event_y,
   output logic                                rsp_last_of_run,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tcgd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcgd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [15:0] max_click_ms_ff;
   logic [9:0]  move_threshold_px_ff;
   logic        csr_fire;

   logic                stage_valid, stage_take;
   tcgd_pkg::stage_type stage_data;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // writes to unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         max_click_ms_ff      <= tcgd_pkg::MAX_CLICK_MS_RESET;
         move_threshold_px_ff <= tcgd_pkg::MOVE_THRESHOLD_PX_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            tcgd_pkg::CSR_MAX_CLICK_MS: begin
               max_click_ms_ff <= csr_wdata;
            end
            tcgd_pkg::CSR_MOVE_THRESHOLD_PX: begin
               move_threshold_px_ff <= csr_wdata[9:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register, touch state, distance squares
   tcgd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_time_ms       (req_time_ms),
      .move_threshold_px (move_threshold_px_ff),
      .stage_take        (stage_take),
      .stage_valid       (stage_valid),
      .stage_data        (stage_data)
   );

   // move flag, click decision, event burst output
   tcgd_events u_events (
      .clock           (clock),
      .reset           (reset),
      .stage_valid     (stage_valid),
      .stage_data      (stage_data),
      .stage_take      (stage_take),
      .max_click_ms    (max_click_ms_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_x     (rsp_event_x),
      .rsp_event_y     (rsp_event_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* src/tcgd_front.sv */
module tcgd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic signed [15:0]    req_pos_x,
   input  logic signed [15:0]    req_pos_y,
   input  logic [31:0]           req_time_ms,
   input  logic [9:0]            move_threshold_px,
   input  logic                  stage_take,
   output logic                  stage_valid,
   output tcgd_pkg::stage_type   stage_data
);

   logic               in_valid_ff, in_valid_in;
   logic               in_action_ff;
   logic signed [15:0] in_x_ff, in_y_ff;
   logic [31:0]        in_time_ff;

   logic               touching_ff, touching_in;
   logic signed [15:0] start_x_ff, start_y_ff, recent_x_ff, recent_y_ff;
   logic [31:0]        press_time_ff;

   logic                s1_valid_ff, s1_valid_in;
   tcgd_pkg::stage_type s1_ff, s1_in;

   logic               s1_free, advance, req_fire;
   logic signed [15:0] base_x, base_y;
   logic signed [16:0] dx, dy;
   logic [16:0]        adx, ady;

   assign s1_free   = !s1_valid_ff || stage_take;
   assign advance   = in_valid_ff && s1_free;
   assign req_stall = in_valid_ff && !s1_free;
   assign req_fire  = req_valid && !req_stall;

   assign stage_valid = s1_valid_ff;
   assign stage_data  = s1_ff;

   // first press measures against itself
   assign base_x = touching_ff ? start_x_ff : in_x_ff;
   assign base_y = touching_ff ? start_y_ff : in_y_ff;
   assign dx  = {in_x_ff[15], in_x_ff} - {base_x[15], base_x};
   assign dy  = {in_y_ff[15], in_y_ff} - {base_y[15], base_y};
   assign adx = dx[16] ? 17'(-dx) : 17'(dx);
   assign ady = dy[16] ? 17'(-dy) : 17'(dy);

   always_comb begin
      s1_in.release_item = in_action_ff;
      s1_in.first_press  = !in_action_ff && !touching_ff;
      s1_in.x            = in_action_ff ? recent_x_ff : in_x_ff;
      s1_in.y            = in_action_ff ? recent_y_ff : in_y_ff;
      s1_in.dx_sq        = 34'(adx) * 34'(adx);
      s1_in.dy_sq        = 34'(ady) * 34'(ady);
      s1_in.thr_sq       = 20'(move_threshold_px) * 20'(move_threshold_px);
      s1_in.elapsed      = in_time_ff - press_time_ff;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      touching_in = touching_ff;
      if (advance) begin
         // release while idle is dropped
         s1_valid_in = !in_action_ff || touching_ff;
         touching_in = !in_action_ff;
      end else if (stage_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         touching_ff   <= 1'b0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         recent_x_ff   <= '0;
         recent_y_ff   <= '0;
         press_time_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         s1_valid_ff <= s1_valid_in;
         touching_ff <= touching_in;
         if (advance && !in_action_ff) begin
            recent_x_ff <= in_x_ff;
            recent_y_ff <= in_y_ff;
            if (!touching_ff) begin
               start_x_ff    <= in_x_ff;
               start_y_ff    <= in_y_ff;
               press_time_ff <= in_time_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_action;
         in_x_ff      <= req_pos_x;
         in_y_ff      <= req_pos_y;
         in_time_ff   <= req_time_ms;
      end
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

endmodule

/* src/tcgd_events.sv */
module tcgd_events (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  tcgd_pkg::stage_type   stage_data,
   output logic                  stage_take,
   input  logic [15:0]           max_click_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_event_kind,
   output logic signed [15:0]    rsp_event_x,
   output logic signed [15:0]    rsp_event_y,
   output logic                  rsp_last_of_run
);

   logic                     moved_ff, moved_in;
   logic [1:0]               cnt_ff, cnt_in;
   tcgd_pkg::event_kind_type kind_ff [3];
   tcgd_pkg::event_kind_type kind_in [3];
   tcgd_pkg::event_kind_type load_kind [3];
   logic [1:0]               load_cnt;
   logic signed [15:0]       ev_x_ff, ev_y_ff;

   logic        rsp_fire, load_ok, load, over, click;
   logic [34:0] dist_sq;

   assign rsp_fire   = rsp_valid && !rsp_stall;
   assign load_ok    = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && !rsp_stall);
   assign stage_take = load_ok;
   assign load       = stage_valid && load_ok;

   assign dist_sq = 35'(stage_data.dx_sq) + 35'(stage_data.dy_sq);
   assign over    = dist_sq > 35'(stage_data.thr_sq);
   assign click   = !moved_ff && (stage_data.elapsed <= 32'(max_click_ms));

   assign rsp_valid       = cnt_ff != 2'd0;
   assign rsp_event_kind  = 3'(kind_ff[0]);
   assign rsp_event_x     = ev_x_ff;
   assign rsp_event_y     = ev_y_ff;
   assign rsp_last_of_run = cnt_ff == 2'd1;

   // events for one item, head first
   always_comb begin
      load_kind[0] = tcgd_pkg::EV_TOUCH;
      load_kind[1] = tcgd_pkg::EV_TOUCH;
      load_kind[2] = tcgd_pkg::EV_NOTOUCH;
      load_cnt     = 2'd1;
      moved_in     = moved_ff;
      if (stage_data.release_item) begin
         load_kind[0] = tcgd_pkg::EV_UP;
         if (click) begin
            load_kind[1] = tcgd_pkg::EV_CLICK;
            load_cnt     = 2'd3;
         end else begin
            load_kind[1] = tcgd_pkg::EV_NOTOUCH;
            load_cnt     = 2'd2;
         end
      end else if (stage_data.first_press) begin
         load_kind[0] = tcgd_pkg::EV_DOWN;
         load_cnt     = 2'd2;
         moved_in     = over;
      end else begin
         moved_in     = moved_ff || over;
      end
   end

   always_comb begin
      kind_in = kind_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         kind_in = load_kind;
         cnt_in  = load_cnt;
      end else if (rsp_fire) begin
         kind_in[0] = kind_ff[1];
         kind_in[1] = kind_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         moved_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (load && !stage_data.release_item) begin
            moved_ff <= moved_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      if (load) begin
         ev_x_ff <= stage_data.x;
         ev_y_ff <= stage_data.y;
      end
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

   // sample actions
   localparam logic ACT_PRESS   = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;
   // register index with no register behind it, writes are dropped
   localparam logic [tcgd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   localparam int DRAIN_CYCLES = 20;      // pipeline is three deep, plenty of margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 160;
   localparam int PHASES       = 6;

   typedef struct {
      logic               action;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0]        stamp;
   } sample_type;

   typedef struct {
      tcgd_pkg::event_kind_type kind;
      logic signed [15:0]       x;
      logic signed [15:0]       y;
      logic                     last;
   } gesture_event_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_action = 1'b0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic [31:0]        req_time_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_event_kind;
   logic signed [15:0] rsp_event_x;
   logic signed [15:0] rsp_event_y;
   logic               rsp_last_of_run;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [tcgd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tcgd_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // samples waiting to be driven, events waiting to come out
   sample_type        sample_queue[$];
   gesture_event_type event_queue[$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  req_taken = 1'b0;   // driven sample was accepted at the last rising edge
   bit  calm = 1'b0;        // no gaps and no stalls while set
   logic [31:0] panel_ms = '0;  // running panel timestamp for generated gestures

   // gesture tracker state, mirrors the block
   logic               touching;
   logic               moved_far;
   logic signed [15:0] origin_x;
   logic signed [15:0] origin_y;
   logic signed [15:0] last_x;
   logic signed [15:0] last_y;
   logic [31:0]        press_stamp;
   logic [15:0]        click_limit_ms;
   logic [9:0]         move_radius_px;

   touch_click_gesture_detector dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_time_ms     (req_time_ms),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_event_x     (rsp_event_x),
      .rsp_event_y     (rsp_event_y),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // idle with a chance of roughly 9 in 100, never while calm
   function automatic bit gap_now();
      return !calm && ($urandom_range(99) < 9);
   endfunction

   task automatic flag_mismatch(input string what);
      error_count++;
      if (error_count <= 40) begin
         $display("%0t: mismatch: %s", $time, what);
      end
   endtask

   task automatic push_event(input tcgd_pkg::event_kind_type kind,
                             input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic last);
      gesture_event_type ev;
      ev.kind = kind;
      ev.x    = x;
      ev.y    = y;
      ev.last = last;
      event_queue.push_back(ev);
   endtask

   // expected events for one accepted sample
   task automatic predict_events(input sample_type s);
      longint      dx;
      longint      dy;
      longint      dist_sq;
      longint      radius_sq;
      logic [31:0] held_ms;
      logic        is_click;
      if (s.action == ACT_PRESS) begin
         // first contact latches the start point and time
         if (!touching) begin
            touching    = 1'b1;
            moved_far   = 1'b0;
            origin_x    = s.x;
            origin_y    = s.y;
            press_stamp = s.stamp;
            push_event(tcgd_pkg::EV_DOWN, s.x, s.y, 1'b0);
         end
         last_x = s.x;
         last_y = s.y;
         // exact squared distance, up to 33 bits
         dx        = longint'(s.x) - longint'(origin_x);
         dy        = longint'(s.y) - longint'(origin_y);
         dist_sq   = dx * dx + dy * dy;
         radius_sq = longint'(move_radius_px) * longint'(move_radius_px);
         if (dist_sq > radius_sq) begin
            moved_far = 1'b1;
         end
         push_event(tcgd_pkg::EV_TOUCH, s.x, s.y, 1'b1);
      end else if (touching) begin
         // elapsed time wraps modulo 2^32
         held_ms  = s.stamp - press_stamp;
         is_click = !moved_far && (held_ms <= {16'd0, click_limit_ms});
         touching = 1'b0;
         push_event(tcgd_pkg::EV_UP, last_x, last_y, 1'b0);
         if (is_click) begin
            push_event(tcgd_pkg::EV_CLICK, last_x, last_y, 1'b0);
         end
         push_event(tcgd_pkg::EV_NOTOUCH, last_x, last_y, 1'b1);
      end
      // release while untouched: nothing
   endtask

   task automatic push_sample(input logic action, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic [31:0] stamp);
      sample_type s;
      s.action = action;
      s.x      = x;
      s.y      = y;
      s.stamp  = stamp;
      sample_queue.push_back(s);
   endtask

   // register write, only while no sample is in flight
   task automatic write_csr(input logic [tcgd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [tcgd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == tcgd_pkg::CSR_MAX_CLICK_MS) begin
         click_limit_ms = data;
      end else if (idx == tcgd_pkg::CSR_MOVE_THRESHOLD_PX) begin
         move_radius_px = data[9:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every sample is in and every event out, then some settle cycles
   task automatic wait_drained(input int settle);
      while (sample_queue.size() != 0 || req_valid || event_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic signed [15:0] jitter(input logic signed [15:0] center,
                                                 input int span);
      return 16'(int'(center) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // one tap or drag: press, up to three moves, usually a release
   task automatic queue_gesture(inout int made);
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic [31:0]        t0;
      logic [31:0]        dur;
      int                 span;
      int                 moves;
      sx = 16'($urandom);
      sy = 16'($urandom);
      if ($urandom_range(3) == 0) begin
         panel_ms = $urandom;
      end
      t0 = panel_ms;
      // mostly hover around the threshold, sometimes fling far away
      span  = ($urandom_range(4) == 0) ? 40000 : int'(move_radius_px) + 2;
      moves = $urandom_range(0, 3);
      push_sample(ACT_PRESS, sx, sy, t0);
      repeat (moves) begin
         push_sample(ACT_PRESS, jitter(sx, span), jitter(sy, span),
                     t0 + $urandom_range(0, 40));
      end
      case ($urandom_range(4))
         0: dur = $urandom_range(0, click_limit_ms);
         1: dur = click_limit_ms;
         2: dur = click_limit_ms + 1;
         3: dur = $urandom;
         default: dur = $urandom_range(0, 2 * click_limit_ms + 2);
      endcase
      // now and then the release is missing and the touch runs on
      if ($urandom_range(7) != 0) begin
         push_sample(ACT_RELEASE, 16'($urandom), 16'($urandom), t0 + dur);
      end
      panel_ms = t0 + dur + $urandom_range(1, 500);
      made += moves + 2;
      // stray samples
      if ($urandom_range(5) == 0) begin
         if ($urandom_range(1) == 0) begin
            push_sample(ACT_RELEASE, 16'($urandom), 16'($urandom), $urandom);
         end else begin
            push_sample(ACT_PRESS, 16'($urandom), 16'($urandom), $urandom);
            made++;
         end
      end
   endtask

   // accept, predict and check at the rising edge
   always @(posedge clock) begin : monitor
      gesture_event_type ev;
      sample_type        s;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            s.action = req_action;
            s.x      = req_pos_x;
            s.y      = req_pos_y;
            s.stamp  = req_time_ms;
            predict_events(s);
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (event_queue.size() == 0) begin
               flag_mismatch($sformatf("unexpected event kind %0d at (%0d,%0d)",
                                       rsp_event_kind, rsp_event_x, rsp_event_y));
            end else begin
               ev = event_queue.pop_front();
               if (rsp_event_kind !== ev.kind) begin
                  flag_mismatch($sformatf("event_kind %0d, want %0d",
                                          rsp_event_kind, ev.kind));
               end
               if (rsp_event_x !== ev.x) begin
                  flag_mismatch($sformatf("event_x %0d, want %0d (kind %0d)",
                                          rsp_event_x, ev.x, ev.kind));
               end
               if (rsp_event_y !== ev.y) begin
                  flag_mismatch($sformatf("event_y %0d, want %0d (kind %0d)",
                                          rsp_event_y, ev.y, ev.kind));
               end
               if (rsp_last_of_run !== ev.last) begin
                  flag_mismatch($sformatf("last_of_run %0b, want %0b (kind %0d)",
                                          rsp_last_of_run, ev.last, ev.kind));
               end
            end
         end
      end
   end

   // drive at the falling edge; a sample holds until accepted
   always @(negedge clock) begin : driver
      sample_type s;
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (sample_queue.size() != 0 && !gap_now()) begin
            s = sample_queue.pop_front();
            req_valid   <= 1'b1;
            req_action  <= s.action;
            req_pos_x   <= s.x;
            req_pos_y   <= s.y;
            req_time_ms <= s.stamp;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= gap_now();
   end

   initial begin : stimulus
      int made;
      int phase;
      touching       = 1'b0;
      moved_far      = 1'b0;
      origin_x       = '0;
      origin_y       = '0;
      last_x         = '0;
      last_y         = '0;
      press_stamp    = '0;
      click_limit_ms = tcgd_pkg::MAX_CLICK_MS_RESET;
      move_radius_px = tcgd_pkg::MOVE_THRESHOLD_PX_RESET;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed, reset registers: limit 300 ms, radius 10 px
      push_sample(ACT_RELEASE, -32768, 32767, 32'hFFFF_FFFF);   // release while untouched
      push_sample(ACT_PRESS, -32768, -32768, 32'd0);            // corner to corner drag
      push_sample(ACT_PRESS, 32767, 32767, 32'd1);
      push_sample(ACT_RELEASE, 0, 0, 32'd2);
      push_sample(ACT_RELEASE, 32767, -32768, 32'd3);           // second release ignored
      push_sample(ACT_PRESS, 100, 100, 32'hFFFF_FF00);          // tap across timestamp wrap
      push_sample(ACT_PRESS, 106, 108, 32'hFFFF_FF40);          // distance equals radius
      push_sample(ACT_RELEASE, -1, -1, 32'd16);
      push_sample(ACT_PRESS, 0, 0, 32'd1000);                   // held exactly the limit
      push_sample(ACT_RELEASE, 0, 0, 32'd1300);
      push_sample(ACT_PRESS, 0, 0, 32'd2000);                   // just past the radius
      push_sample(ACT_PRESS, 7, 8, 32'd2000);
      push_sample(ACT_RELEASE, 0, 0, 32'd2001);
      push_sample(ACT_PRESS, 5, -5, 32'd3000);                  // one ms too long
      push_sample(ACT_RELEASE, 5, -5, 32'd3301);
      // register change in the middle of a touch
      push_sample(ACT_PRESS, 0, 0, 32'd5000);
      push_sample(ACT_PRESS, 3, 4, 32'd5010);
      wait_drained(DRAIN_CYCLES);
      write_csr(tcgd_pkg::CSR_MOVE_THRESHOLD_PX, 16'd0);
      push_sample(ACT_PRESS, 0, 0, 32'd5020);
      wait_drained(DRAIN_CYCLES);
      write_csr(tcgd_pkg::CSR_MAX_CLICK_MS, 16'd0);
      push_sample(ACT_RELEASE, 0, 0, 32'd5000);                 // zero elapsed still clicks
      push_sample(ACT_PRESS, -1, 0, 32'd6000);                  // zero radius, one pixel moves
      push_sample(ACT_PRESS, -1, 1, 32'd6000);
      push_sample(ACT_RELEASE, 0, 0, 32'd6000);
      wait_drained(DRAIN_CYCLES);
      // top of range; upper data bits of the radius are dropped
      write_csr(CSR_SPARE_INDEX, 16'hFFFF);
      write_csr(tcgd_pkg::CSR_MAX_CLICK_MS, 16'hFFFF);
      write_csr(tcgd_pkg::CSR_MOVE_THRESHOLD_PX, 16'hFFFF);
      push_sample(ACT_PRESS, 0, 0, 32'd0);
      push_sample(ACT_PRESS, 1023, 0, 32'd9);
      push_sample(ACT_RELEASE, 0, 0, 32'd65535);
      push_sample(ACT_PRESS, 0, 0, 32'd100);
      push_sample(ACT_PRESS, 1023, 1, 32'd100);
      push_sample(ACT_RELEASE, 0, 0, 32'd65636);

      // random gestures, a register setting per phase
      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained(DRAIN_CYCLES);
         case (phase)
            1: begin
               write_csr(tcgd_pkg::CSR_MAX_CLICK_MS, 16'd0);
               write_csr(tcgd_pkg::CSR_MOVE_THRESHOLD_PX, 16'd0);
            end
            3: begin
               write_csr(tcgd_pkg::CSR_MAX_CLICK_MS, 16'hFFFF);
               write_csr(tcgd_pkg::CSR_MOVE_THRESHOLD_PX, 16'h03FF);
            end
            4: begin
               write_csr(tcgd_pkg::CSR_MAX_CLICK_MS, 16'($urandom));
               write_csr(tcgd_pkg::CSR_MOVE_THRESHOLD_PX, 16'($urandom));
            end
            default: begin
               write_csr(tcgd_pkg::CSR_MAX_CLICK_MS, 16'($urandom_range(0, 1000)));
               write_csr(tcgd_pkg::CSR_MOVE_THRESHOLD_PX, 16'($urandom_range(0, 40)));
            end
         endcase
         // one phase runs without any gaps or stalls
         calm = (phase == 2);
         made = 0;
         while (made < RANDOM_ITEMS / PHASES) begin
            queue_gesture(made);
            // sender holds off until every event is out
            if ($urandom_range(11) == 0) begin
               wait_drained(0);
            end
         end
      end

      wait_drained(DRAIN_CYCLES);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
